// ===== design/scs_pkg.sv =====
// Shared types, constants and helpers for the source comment stripper.
// Used by the lexer front end, the command queue, the emitter and the top level.
// No dependencies.
package scs_pkg;

    // Default depth of the held-whitespace store
    localparam int HOLD_DEPTH_DEF = 32;

    // Depth of the command queue between the lexer and the emitter
    localparam int CMD_DEPTH = 4;

    // Language codes (code 3 is treated as C)
    localparam logic [1:0] LANG_C     = 2'd0;
    localparam logic [1:0] LANG_SHELL = 2'd1;
    localparam logic [1:0] LANG_ASM   = 2'd2;

    // Characters the lexer and emitter look for
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // One command from the lexer: up to three emits in order, then end-of-file work
    typedef struct packed {
        logic       pre_slash;   // emit a deferred slash first
        logic       keep_byte;   // emit the text byte
        logic       post_slash;  // emit a slash still pending at end of file
        logic       file_end;    // run end-of-file flush and clear afterwards
        logic [7:0] text;
    } scs_cmd_t;

    // Whitespace other than newline
    function automatic logic is_ws(input logic [7:0] b);
        return b inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

endpackage

// ===== design/scs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds data only; no reset. No dependencies.
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/scs_lexer.sv =====
// Front end: accepts one text byte per cycle while the command queue has room, tracks
// comment and literal state, and turns each byte into an emit command. Depends on scs_pkg.
module scs_lexer import scs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] language,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_text,
    input  logic       in_end,
    input  logic       q_full,
    output logic       push,
    output scs_cmd_t   push_cmd
);

    typedef enum logic [4:0] {
        LX_NORMAL = 5'b00001,
        LX_LINE   = 5'b00010,
        LX_BLOCK  = 5'b00100,
        LX_STRING = 5'b01000,
        LX_CHAR   = 5'b10000
    } lex_state_t;

    lex_state_t lex_reg, lex_next;
    logic       pslash_reg, pslash_next;
    logic       pstar_reg, pstar_next;
    logic       esc_reg, esc_next;
    logic       cmode;
    logic       take_normal;
    logic       accept;
    logic [7:0] close_char;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cmode    = (language != LANG_SHELL) && (language != LANG_ASM);

    // Classify the byte against the current lexer state
    always_comb begin
        lex_next    = lex_reg;
        pslash_next = pslash_reg;
        pstar_next  = pstar_reg;
        esc_next    = esc_reg;
        take_normal = 1'b0;
        close_char  = (lex_reg == LX_STRING) ? CH_DQUOTE : CH_SQUOTE;
        push_cmd    = '0;
        push_cmd.text     = in_text;
        push_cmd.file_end = in_end;

        case (lex_reg)
            LX_LINE: begin
                if (in_text == CH_NL) begin
                    lex_next           = LX_NORMAL;
                    push_cmd.keep_byte = 1'b1;
                end
            end
            LX_BLOCK: begin
                if (pstar_reg && in_text == CH_SLASH) begin
                    pstar_next = 1'b0;
                    lex_next   = LX_NORMAL;
                end else begin
                    pstar_next = (in_text == CH_STAR);
                end
            end
            LX_STRING, LX_CHAR: begin
                if (esc_reg) begin
                    // escaped byte is kept in strings, dropped in char literals
                    esc_next           = 1'b0;
                    push_cmd.keep_byte = (lex_reg == LX_STRING);
                end else begin
                    push_cmd.keep_byte = 1'b1;
                    if (in_text == close_char) begin
                        lex_next = LX_NORMAL;
                    end else if (in_text == CH_BSLASH) begin
                        esc_next = 1'b1;
                    end
                end
            end
            default: begin
                lex_next    = LX_NORMAL;
                take_normal = 1'b1;
                // resolve a slash held from the previous byte
                if (pslash_reg) begin
                    pslash_next = 1'b0;
                    if (cmode && in_text == CH_SLASH) begin
                        lex_next    = LX_LINE;
                        take_normal = 1'b0;
                    end else if (cmode && in_text == CH_STAR) begin
                        lex_next    = LX_BLOCK;
                        pstar_next  = 1'b0;
                        take_normal = 1'b0;
                    end else begin
                        push_cmd.pre_slash = 1'b1;
                    end
                end
            end
        endcase

        // Normal text handling
        if (take_normal) begin
            if (esc_reg) begin
                esc_next           = 1'b0;
                push_cmd.keep_byte = 1'b1;
            end else if (in_text == CH_SQUOTE) begin
                lex_next           = LX_CHAR;
                push_cmd.keep_byte = 1'b1;
            end else if (in_text == CH_DQUOTE) begin
                lex_next           = LX_STRING;
                push_cmd.keep_byte = 1'b1;
            end else if (language == LANG_SHELL && in_text == CH_HASH) begin
                lex_next = LX_LINE;
            end else if (language == LANG_SHELL && in_text == CH_BSLASH) begin
                push_cmd.keep_byte = 1'b1;
                esc_next           = 1'b1;
            end else if (language == LANG_ASM && in_text == CH_SEMI) begin
                lex_next = LX_LINE;
            end else if (cmode && in_text == CH_SLASH) begin
                pslash_next = 1'b1;
            end else begin
                push_cmd.keep_byte = 1'b1;
            end
        end

        // End of file: flush a pending slash and return to reset state
        if (in_end) begin
            push_cmd.post_slash = pslash_next;
            lex_next    = LX_NORMAL;
            pslash_next = 1'b0;
            pstar_next  = 1'b0;
            esc_next    = 1'b0;
        end
    end

    // Drop commands that would do nothing in the back end
    assign push = accept && (push_cmd.pre_slash || push_cmd.keep_byte ||
                             push_cmd.post_slash || push_cmd.file_end);

    // Lexer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lex_reg    <= LX_NORMAL;
            pslash_reg <= 1'b0;
            pstar_reg  <= 1'b0;
            esc_reg    <= 1'b0;
        end else if (accept) begin
            lex_reg    <= lex_next;
            pslash_reg <= pslash_next;
            pstar_reg  <= pstar_next;
            esc_reg    <= esc_next;
        end
    end

endmodule

// ===== design/scs_cmd_queue.sv =====
// Short command queue between the lexer and the emitter.
// Depends on scs_pkg for the command type and depth.
module scs_cmd_queue import scs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  scs_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output scs_cmd_t head_cmd
);

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    scs_cmd_t        entries_reg [CMD_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(CMD_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the payload
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/scs_emitter.sv =====
// Back end: carries out emit commands and, when remove_blank is set, holds leading
// whitespace in a RAM and drops blank lines; drives the output stream. Depends on scs_pkg, scs_ram.
module scs_emitter import scs_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       remove_blank,
    input  logic       cmd_valid,
    input  scs_cmd_t   cmd_head,
    output logic       cmd_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(HOLD_DEPTH);

    typedef enum logic [3:0] {
        ST_FETCH = 4'b0001,
        ST_EMIT  = 4'b0010,
        ST_REL   = 4'b0100,
        ST_PUT   = 4'b1000
    } emit_state_t;

    emit_state_t   state_reg, state_next;
    scs_cmd_t      cmd_reg, cmd_next;
    logic [CW-1:0] held_cnt_reg, held_next;
    logic          lht_reg, lht_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rel_end_reg, rel_end_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_data_reg, pend_data_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    logic          adv;
    logic [7:0]    cur_byte;
    logic          any_emit;
    logic [2:0]    mask_after;
    logic          is_nl;
    logic          hold_case;
    logic          needs_rel;
    logic          end_rel;
    logic          finish;
    logic          put_en;
    logic [7:0]    put_data;
    logic          flush_en;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    // Held whitespace store
    scs_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Advance only when the output register can take a beat
    assign adv = !out_valid_reg || m_tready;

    // Decode the current emit of the command
    always_comb begin
        any_emit = cmd_reg.pre_slash || cmd_reg.keep_byte || cmd_reg.post_slash;
        if (cmd_reg.pre_slash) begin
            cur_byte   = CH_SLASH;
            mask_after = {1'b0, cmd_reg.keep_byte, cmd_reg.post_slash};
        end else if (cmd_reg.keep_byte) begin
            cur_byte   = cmd_reg.text;
            mask_after = {2'b00, cmd_reg.post_slash};
        end else begin
            cur_byte   = CH_SLASH;
            mask_after = 3'b000;
        end
        is_nl     = (cur_byte == CH_NL);
        hold_case = !is_nl && remove_blank && !lht_reg && is_ws(cur_byte) &&
                    (held_cnt_reg < DEPTH_CNT);
        needs_rel = is_nl ? (!remove_blank || lht_reg) : !hold_case;
        end_rel   = !(remove_blank && !lht_reg);
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        held_next    = held_cnt_reg;
        lht_next     = lht_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = rd_pend_reg;
        rel_end_next = rel_end_reg;
        cmd_pop      = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = held_cnt_reg[AW-1:0];
        ram_wr_data  = cur_byte;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = rd_idx_reg[AW-1:0];
        put_en       = 1'b0;
        put_data     = cur_byte;
        flush_en     = 1'b0;
        finish       = 1'b0;

        if (adv) begin
            case (state_reg)
                ST_FETCH: begin
                    // close the previous item's run and take the next command
                    flush_en = pend_valid_reg;
                    if (cmd_valid) begin
                        cmd_pop    = 1'b1;
                        cmd_next   = cmd_head;
                        state_next = ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (any_emit) begin
                        if (needs_rel && held_cnt_reg != '0) begin
                            // start releasing held whitespace before the byte
                            ram_rd_en    = 1'b1;
                            ram_rd_addr  = '0;
                            rd_idx_next  = CW'(1);
                            rd_pend_next = 1'b1;
                            rel_end_next = 1'b0;
                            state_next   = ST_REL;
                        end else begin
                            finish = 1'b1;
                            if (is_nl) begin
                                put_en    = needs_rel;
                                held_next = '0;
                                lht_next  = 1'b0;
                            end else if (hold_case) begin
                                ram_wr_en = 1'b1;
                                held_next = held_cnt_reg + CW'(1);
                            end else begin
                                put_en   = 1'b1;
                                lht_next = 1'b1;
                            end
                        end
                    end else if (cmd_reg.file_end && end_rel && held_cnt_reg != '0) begin
                        // end of file on a line with text: release what is held
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = '0;
                        rd_idx_next  = CW'(1);
                        rd_pend_next = 1'b1;
                        rel_end_next = 1'b1;
                        state_next   = ST_REL;
                    end else begin
                        if (cmd_reg.file_end) begin
                            held_next = '0;
                            lht_next  = 1'b0;
                        end
                        state_next = ST_FETCH;
                    end
                end
                ST_REL: begin
                    // one held byte out per cycle while the output can take a beat, next read issued alongside
                    if (rd_pend_reg) begin
                        put_en   = 1'b1;
                        put_data = ram_rd_data;
                    end
                    if (rd_idx_reg < held_cnt_reg) begin
                        ram_rd_en    = 1'b1;
                        rd_idx_next  = rd_idx_reg + CW'(1);
                        rd_pend_next = 1'b1;
                    end else begin
                        rd_pend_next = 1'b0;
                        held_next    = '0;
                        if (rel_end_reg) begin
                            lht_next   = 1'b0;
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_PUT;
                        end
                    end
                end
                ST_PUT: begin
                    // byte that follows a release
                    put_en   = 1'b1;
                    lht_next = !is_nl;
                    finish   = 1'b1;
                end
                default: begin
                    state_next = ST_FETCH;
                end
            endcase
        end

        // Retire the current emit and pick where to go
        if (finish) begin
            cmd_next.pre_slash  = mask_after[2];
            cmd_next.keep_byte  = mask_after[1];
            cmd_next.post_slash = mask_after[0];
            state_next = (mask_after == 3'b000 && !cmd_reg.file_end) ? ST_FETCH : ST_EMIT;
        end
    end

    // Output staging: a beat is held in the pending register until it is known to be last or not
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        if (put_en) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = pend_data_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_data_next  = put_data;
        end else if (flush_en) begin
            out_valid_next  = 1'b1;
            out_data_next   = pend_data_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers and the current command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FETCH;
            held_cnt_reg   <= '0;
            lht_reg        <= 1'b0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            rel_end_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cmd_reg.pre_slash  <= 1'b0;
            cmd_reg.keep_byte  <= 1'b0;
            cmd_reg.post_slash <= 1'b0;
            cmd_reg.file_end   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_cnt_reg   <= held_next;
            lht_reg        <= lht_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= rd_pend_next;
            rel_end_reg    <= rel_end_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_data_reg <= pend_data_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Held count never passes the store depth
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg <= DEPTH_CNT)
        else $error("held whitespace count exceeds store depth");

    // Whitespace is only held on a line without text
    a_held_no_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_cnt_reg != '0) |-> !lht_reg)
        else $error("whitespace held on a line that already has text");

    // RAM read data is only outstanding during a release
    a_rd_in_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_REL))
        else $error("read outstanding outside release");

    // Closing a run puts a last beat on the output
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH && adv && pend_valid_reg) |=> (m_tvalid && m_tlast))
        else $error("run end did not produce a last beat");

endmodule

// ===== design/source_comment_stripper_unit.sv =====
// Source comment stripper: takes one text byte per beat (tlast marks end of file)
// and returns the text with comments removed, optionally with blank lines dropped.
// Depends on scs_pkg, scs_lexer, scs_cmd_queue, scs_emitter and scs_ram.
//
// The lexer front end takes a byte every cycle while its four-entry command queue
// has room; bytes inside comments cost nothing further. In the emitter each byte
// that yields a command (a kept or held byte, or the end of the file) passes a
// command fetch and an emit step, plus a further emit for each slash emitted
// with it. A byte that releases held whitespace first reads the held bytes out
// one a cycle through the store's registered read port while the output can
// take a beat, then emits its own byte; an end-of-file beat releases held bytes
// before fetch. Held whitespace needs no clearing pass after reset. The last
// beat of the results of one input byte carries m_tlast, and a byte that yields
// no result produces no beat. Registers: language at 0x0 (0 C/C++, 1 shell,
// 2 assembler, 3 as C), remove_blank at 0x4; write them only while idle.
module source_comment_stripper_unit import scs_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // file_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] kept_byte
    output logic        m_tlast,   // run_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_LANGUAGE     = 1'b0;
    localparam logic REG_REMOVE_BLANK = 1'b1;

    logic       rd_language;
    logic [1:0] language_val_reg;
    logic       remove_blank_reg;
    logic       cfg_write;
    logic       q_full;
    logic       q_push;
    scs_cmd_t   q_push_cmd;
    logic       q_pop;
    logic       q_head_valid;
    scs_cmd_t   q_head_cmd;

    // Register port
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign rd_language = (paddr[2] == REG_LANGUAGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            language_val_reg <= LANG_C;
            remove_blank_reg <= 1'b1;
        end else if (cfg_write) begin
            if (paddr[2] == REG_REMOVE_BLANK) begin
                remove_blank_reg <= pwdata[0];
            end else begin
                language_val_reg <= pwdata[1:0];
            end
        end
    end

    assign prdata = rd_language ? {30'd0, language_val_reg} : {31'd0, remove_blank_reg};

    // Front end
    scs_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .language (language_val_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_text  (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    // Queue between front and back
    scs_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back end
    scs_emitter #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .remove_blank (remove_blank_reg),
        .cmd_valid    (q_head_valid),
        .cmd_head     (q_head_cmd),
        .cmd_pop      (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
